// ===== rtl/retransmit_timer_rto_tracker_defines.svh =====
// assertion macros for the rto tracker
`ifndef RETRANSMIT_TIMER_RTO_TRACKER_DEFINES_SVH
`define RETRANSMIT_TIMER_RTO_TRACKER_DEFINES_SVH
// implication checked every clock outside reset
`define RTT_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication checked every clock outside reset
`define RTT_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// ===== rtl/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg
// shared types and constants of the retransmit timer rto tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rtt_pkg;
  localparam int unsigned WindowSlots = 16;
  localparam int unsigned SlotW = $clog2(WindowSlots);
  localparam int unsigned CntW = $clog2(WindowSlots + 1);
  localparam logic [15:0] MaxPayload = 16'd1200;
  localparam logic [19:0] M20 = 20'hFFFFF;
  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] CmdSend = 2'd0;
  localparam logic [1:0] CmdTick = 2'd1;
  localparam logic [1:0] CmdAck  = 2'd2;

  localparam logic [2:0] StSent    = 3'd0;
  localparam logic [2:0] StRetx    = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StTooLong = 3'd3;
  localparam logic [2:0] StStale   = 3'd4;
  localparam logic [2:0] StNone    = 3'd5;

  localparam logic [1:0] RegInitRto = 2'd0;
  localparam logic [1:0] RegFloor   = 2'd1;
  localparam logic [1:0] RegCeil    = 2'd2;

  // estimator request/response between the sequencer and the estimator
  typedef struct packed {
    logic        start;
    logic [19:0] sample;
  } est_req_t;

  typedef struct packed {
    logic        busy;
    logic        have;
    logic [19:0] base;
  } est_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/rtt_estimator.sv =====
// ----------------------------------------------------------------------------
// rtt_estimator
// jacobson/karels smoothed rtt/variance, three steps per sample (first: two)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rtt_estimator (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rtt_pkg::est_req_t req_i,
  input  wire logic             init_wr_i,
  input  wire logic [19:0]      init_val_i,
  input  wire logic [19:0]      floor_i,
  output rtt_pkg::est_rsp_t     rsp_o
);
  typedef enum logic [1:0] {EsIdle, EsVar, EsSrtt, EsRto} est_state_e;
  est_state_e  state_q;
  logic [19:0] smp_q, srtt_q, var_q, base_q;
  logic        have_q;
  logic [19:0] diff;
  logic [22:0] var_sum;
  logic [22:0] srtt_sum;
  logic [22:0] rto_sum;
  logic [19:0] rto_sat;

  always_comb begin
    diff = (srtt_q > smp_q) ? srtt_q - smp_q : smp_q - srtt_q;
    var_sum = 23'(var_q) * 23'd3 + 23'(diff);
    srtt_sum = 23'(srtt_q) * 23'd7 + 23'(smp_q);
    rto_sum = 23'(srtt_q) + 23'({var_q, 2'b00});
    rto_sat = (rto_sum > 23'(rtt_pkg::M20)) ? rtt_pkg::M20 : rto_sum[19:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EsIdle;
      have_q <= 1'b0;
      srtt_q <= '0;
      var_q <= '0;
      base_q <= 20'd1000;
      smp_q <= '0;
    end else begin
      unique case (state_q)
        EsIdle: begin
          if (req_i.start) begin
            smp_q <= req_i.sample;
            state_q <= EsVar;
          end else if (init_wr_i && !have_q) begin
            base_q <= init_val_i;
          end
        end
        EsVar: begin
          if (!have_q) begin
            srtt_q <= smp_q;
            var_q <= {1'b0, smp_q[19:1]};
            have_q <= 1'b1;
            state_q <= EsRto;
          end else begin
            var_q <= var_sum[21:2];
            state_q <= EsSrtt;
          end
        end
        EsSrtt: begin
          srtt_q <= srtt_sum[22:3];
          state_q <= EsRto;
        end
        EsRto: begin
          base_q <= (rto_sat < floor_i) ? floor_i : rto_sat;
          state_q <= EsIdle;
        end
        default: state_q <= EsIdle;
      endcase
    end
  end

  assign rsp_o.busy = (state_q != EsIdle);
  assign rsp_o.have = have_q;
  assign rsp_o.base = base_q;
endmodule
`default_nettype wire

// ===== rtl/retransmit_timer_rto_tracker.sv =====
// ----------------------------------------------------------------------------
// retransmit_timer_rto_tracker
// slot table of outstanding packets with per-slot timers and rto estimation
// ----------------------------------------------------------------------------
// send: accept, slot write, result; tick: slots read and evaluated in turn
// ack: slots scanned likewise, each rtt sample through the shared estimator
// one command at a time
// reset clears slot valid bits and estimator state at once, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module retransmit_timer_rto_tracker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [19:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [47:0] now_time_i,
  input  wire logic [31:0] ack_number_i,
  input  wire logic [15:0] payload_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [31:0]      seq_out_o,
  output logic [5:0]       slot_out_o,
  output logic [6:0]       in_flight_o,
  output logic [19:0]      base_rto_out_o
);
  localparam int unsigned N = rtt_pkg::WindowSlots;
  localparam int unsigned SW = rtt_pkg::SlotW;

  typedef enum logic [2:0] {
    SIdle, SRead, SEval, SEst, SWrite, SDone
  } state_e;

  state_e state_q;
  logic [SW-1:0] idx_q;
  logic [1:0] cmd_q;
  logic [47:0] now_q;
  logic [31:0] ack_q;
  logic [N-1:0] valid_q;
  logic [31:0] next_seq_q, high_ack_q;
  logic [rtt_pkg::CntW-1:0] count_q;
  logic [19:0] floor_q, ceil_q;
  logic [2:0] status_q;
  logic [31:0] seq_q;
  logic [5:0] slot_q;
  logic out_valid_q;

  logic [31:0] mem_seq [N];
  logic [47:0] mem_sent [N];
  logic [19:0] mem_to [N];
  logic [47:0] mem_due [N];
  logic [N-1:0] once_q;
  logic [31:0] rd_seq;
  logic [47:0] rd_sent, rd_due;
  logic [19:0] rd_to;
  logic rd_once;

  logic wr_en;
  logic [SW-1:0] wr_idx;
  logic [31:0] wr_seq;
  logic [47:0] wr_sent, wr_due;
  logic [19:0] wr_to;

  rtt_pkg::est_req_t est_req;
  rtt_pkg::est_rsp_t est_rsp;
  logic [19:0] new_to_q, smp_q;
  logic [48:0] due_sum;
  logic [20:0] dbl;
  logic [48:0] rtt_diff;
  logic free_found;
  logic [SW-1:0] free_idx;
  logic last;

  assign cfg_ready_o = (state_q == SIdle) && !out_valid_q;
  assign in_ready_o = (state_q == SIdle) && !out_valid_q;

  rtt_estimator u_est (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (est_req),
    .init_wr_i (cfg_valid_i && cfg_ready_o && cfg_index_i == rtt_pkg::RegInitRto),
    .init_val_i(cfg_data_i),
    .floor_i   (floor_q),
    .rsp_o     (est_rsp)
  );

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // slot table memories
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_seq[wr_idx] <= wr_seq;
      mem_sent[wr_idx] <= wr_sent;
      mem_to[wr_idx] <= wr_to;
      mem_due[wr_idx] <= wr_due;
    end
    rd_seq <= mem_seq[idx_q];
    rd_sent <= mem_sent[idx_q];
    rd_to <= mem_to[idx_q];
    rd_due <= mem_due[idx_q];
    rd_once <= once_q[idx_q];
  end

  always_comb begin
    due_sum = 49'(now_q) + 49'(new_to_q);
    dbl = {rd_to, 1'b0};
    rtt_diff = 49'(now_q) - 49'(rd_sent);
    last = (idx_q == SW'(N - 1));
    wr_en = (state_q == SWrite);
    wr_idx = idx_q;
    wr_seq = (cmd_q == rtt_pkg::CmdSend) ? next_seq_q : rd_seq;
    wr_sent = now_q;
    wr_to = new_to_q;
    wr_due = due_sum[48] ? rtt_pkg::M48 : due_sum[47:0];
    est_req.start = (state_q == SEst) && !est_rsp.busy;
    est_req.sample = smp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      valid_q <= '0;
      once_q <= '0;
      next_seq_q <= 32'd1;
      high_ack_q <= '0;
      count_q <= '0;
      floor_q <= 20'd200;
      ceil_q <= 20'd60000;
      out_valid_q <= 1'b0;
      idx_q <= '0;
      cmd_q <= '0;
      status_q <= '0;
      seq_q <= '0;
      slot_q <= '0;
      now_q <= '0;
      ack_q <= '0;
      new_to_q <= '0;
      smp_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          rtt_pkg::RegInitRto: ;
          rtt_pkg::RegFloor:   floor_q <= cfg_data_i;
          rtt_pkg::RegCeil:    ceil_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        SIdle: begin
          if (in_valid_i && in_ready_o) begin
            cmd_q <= cmd_i;
            now_q <= now_time_i;
            ack_q <= ack_number_i;
            status_q <= rtt_pkg::StNone;
            seq_q <= '0;
            slot_q <= '0;
            idx_q <= '0;
            state_q <= SRead;
            priority if (cmd_i == rtt_pkg::CmdSend) begin
              if (payload_length_i > rtt_pkg::MaxPayload) begin
                status_q <= rtt_pkg::StTooLong;
                state_q <= SDone;
              end else if (!free_found) begin
                status_q <= rtt_pkg::StFull;
                state_q <= SDone;
              end else begin
                idx_q <= free_idx;
                new_to_q <= est_rsp.base;
                state_q <= SWrite;
              end
            end else if (cmd_i == rtt_pkg::CmdAck) begin
              if (ack_number_i <= high_ack_q) begin
                status_q <= rtt_pkg::StStale;
                state_q <= SDone;
              end else begin
                high_ack_q <= ack_number_i;
              end
            end else if (cmd_i != rtt_pkg::CmdTick) begin
              state_q <= SDone;
            end
          end
        end
        SRead: state_q <= SEval;
        SEval: begin
          if (cmd_q == rtt_pkg::CmdTick) begin
            if (valid_q[idx_q] && now_q >= rd_due) begin
              new_to_q <= (dbl > 21'(ceil_q)) ? ceil_q : dbl[19:0];
              status_q <= rtt_pkg::StRetx;
              seq_q <= rd_seq;
              slot_q <= 6'(idx_q);
              state_q <= SWrite;
            end else if (last) begin
              state_q <= SDone;
            end else begin
              idx_q <= idx_q + 1'b1;
              state_q <= SRead;
            end
          end else begin
            if (valid_q[idx_q] && rd_seq <= ack_q) begin
              valid_q[idx_q] <= 1'b0;
              if (count_q != '0) count_q <= count_q - 1'b1;
              smp_q <= rtt_diff[48] ? 20'd0 :
                       (rtt_diff[47:20] != '0) ? rtt_pkg::M20 : rtt_diff[19:0];
            end
            if (valid_q[idx_q] && rd_seq <= ack_q && rd_once) begin
              state_q <= SEst;
            end else if (last) begin
              state_q <= SDone;
            end else begin
              idx_q <= idx_q + 1'b1;
              state_q <= SRead;
            end
          end
        end
        SEst: begin
          if (!est_rsp.busy) begin
            if (last) state_q <= SDone;
            else begin
              idx_q <= idx_q + 1'b1;
              state_q <= SRead;
            end
          end
        end
        SWrite: begin
          if (cmd_q == rtt_pkg::CmdSend) begin
            valid_q[idx_q] <= 1'b1;
            once_q[idx_q] <= 1'b1;
            status_q <= rtt_pkg::StSent;
            seq_q <= next_seq_q;
            slot_q <= 6'(idx_q);
            next_seq_q <= next_seq_q + 32'd1;
            count_q <= count_q + 1'b1;
          end else begin
            once_q[idx_q] <= 1'b0;
          end
          state_q <= SDone;
        end
        SDone: begin
          if (!est_rsp.busy) begin
            out_valid_q <= 1'b1;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign seq_out_o = seq_q;
  assign slot_out_o = slot_q;
  assign in_flight_o = 7'(count_q);
  assign base_rto_out_o = est_rsp.base;
endmodule
`default_nettype wire

// ===== rtl/rtt_checker.sv =====
// ----------------------------------------------------------------------------
// rtt_checker
// port-level checks of the rto tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "retransmit_timer_rto_tracker_defines.svh"
module rtt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic [6:0]  in_flight_o
);
  `RTT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `RTT_ASSERT_IMP(a_no_accept_pending, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `RTT_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o, status_o <= 3'd5)
  `RTT_ASSERT_IMP(a_flight_range, clk_i, rst_ni, out_valid_o, in_flight_o <= 7'd16)
  `RTT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule

bind retransmit_timer_rto_tracker rtt_checker u_rtt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .in_flight_o (in_flight_o)
);
`default_nettype wire

// ===== sim/retransmit_timer_rto_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// retransmit_timer_rto_tracker_tb
// drives send, tick, ack and unused commands via valid/ready with random gaps
// and output stalls; checks every response field against fixed values or a
// slot-table/estimator predictor in the bench, over several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module retransmit_timer_rto_tracker_tb;
  localparam logic [1:0] CmdNone   = 2'd3;
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int         NSlots    = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] seq;
    logic [5:0]  slot;
    logic [6:0]  in_flight;
    logic [19:0] base_rto;
  } rto_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [47:0] now;
    logic [31:0] ack;
    logic [15:0] len;
    bit          typed;
    rto_result_t res;
  } cmd_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [19:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [47:0] now_time_i = '0;
  logic [31:0] ack_number_i = '0;
  logic [15:0] payload_length_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] seq_out_o;
  logic [5:0]  slot_out_o;
  logic [6:0]  in_flight_o;
  logic [19:0] base_rto_out_o;

  retransmit_timer_rto_tracker dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [19:0] p_init, p_floor, p_ceil;
  bit          p_valid [NSlots];
  logic [31:0] p_seq [NSlots];
  logic [47:0] p_sent [NSlots];
  logic [19:0] p_tmo [NSlots];
  logic [47:0] p_due [NSlots];
  bit          p_once [NSlots];
  logic [31:0] p_next, p_high;
  int          p_count;
  bit          p_have;
  logic [19:0] p_srtt, p_var, p_base;

  rto_result_t expected_q [$];
  int          mismatches = 0;
  int          status_seen [8];
  int          items = 0;
  int          burst_left = 0;
  bit          hold_req = 0;
  logic [47:0] clk_ms = '0;
  cmd_row_t    directed [21];

  function automatic logic [47:0] due_after(logic [47:0] now, logic [19:0] t);
    longint unsigned d;
    d = longint'(now) + longint'(t);
    return (d > longint'(rtt_pkg::M48)) ? rtt_pkg::M48 : d[47:0];
  endfunction

  task automatic estimate_rto(input logic [19:0] sample);
    longint unsigned rto;
    logic [19:0]     diff;
    if (!p_have) begin
      p_srtt = sample;
      p_var  = sample >> 1;
      p_have = 1;
    end else begin
      diff   = (p_srtt > sample) ? p_srtt - sample : sample - p_srtt;
      p_var  = 20'((64'd3 * p_var + diff) / 64'd4);
      p_srtt = 20'((64'd7 * p_srtt + sample) / 64'd8);
    end
    rto = longint'(p_srtt) + 4 * longint'(p_var);
    if (rto > longint'(rtt_pkg::M20)) rto = rtt_pkg::M20;
    if (rto < longint'(p_floor)) rto = p_floor;
    p_base = rto[19:0];
  endtask

  task automatic predict_step(input logic [1:0] c, input logic [47:0] now,
                              input logic [31:0] ack, input logic [15:0] len,
                              output rto_result_t r);
    int              i;
    longint unsigned dbl, s;
    r = '{status: rtt_pkg::StNone, default: '0};
    if (c == rtt_pkg::CmdSend) begin
      if (len > rtt_pkg::MaxPayload) r.status = rtt_pkg::StTooLong;
      else if (p_count >= NSlots) r.status = rtt_pkg::StFull;
      else begin
        for (i = 0; i < NSlots; i++) if (!p_valid[i]) break;
        r.status = rtt_pkg::StSent;
        r.seq    = p_next;
        r.slot   = 6'(i);
        p_valid[i] = 1;
        p_seq[i]   = p_next;
        p_sent[i]  = now;
        p_tmo[i]   = p_base;
        p_due[i]   = due_after(now, p_base);
        p_once[i]  = 1;
        p_next     = p_next + 32'd1;
        p_count++;
      end
    end else if (c == rtt_pkg::CmdTick) begin
      for (i = 0; i < NSlots; i++) begin
        if (p_valid[i] && now >= p_due[i]) begin
          dbl = 2 * longint'(p_tmo[i]);
          if (dbl > longint'(p_ceil)) dbl = p_ceil;
          p_tmo[i]  = dbl[19:0];
          p_sent[i] = now;
          p_due[i]  = due_after(now, p_tmo[i]);
          p_once[i] = 0;
          r.status  = rtt_pkg::StRetx;
          r.seq     = p_seq[i];
          r.slot    = 6'(i);
          break;
        end
      end
    end else if (c == rtt_pkg::CmdAck) begin
      if (ack <= p_high) r.status = rtt_pkg::StStale;
      else begin
        p_high = ack;
        for (i = 0; i < NSlots; i++) begin
          if (p_valid[i] && p_seq[i] <= ack) begin
            if (p_once[i]) begin
              s = (now >= p_sent[i]) ? longint'(now - p_sent[i]) : 0;
              if (s > longint'(rtt_pkg::M20)) s = rtt_pkg::M20;
              estimate_rto(s[19:0]);
            end
            p_valid[i] = 0;
            if (p_count > 0) p_count--;
          end
        end
      end
    end
    r.in_flight = 7'(p_count);
    r.base_rto  = p_base;
  endtask

  task automatic drive_cmd(input logic [1:0] c, input logic [47:0] now,
                           input logic [31:0] ack, input logic [15:0] len,
                           input bit typed = 0, input rto_result_t typed_res = '0);
    int          gap;
    rto_result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    cmd_i            <= c;
    now_time_i       <= now;
    ack_number_i     <= ack;
    payload_length_i <= len;
    do @(posedge clk_i); while (!in_ready_o);
    predict_step(c, now, ack, len, r);
    status_seen[r.status]++;
    items++;
    expected_q.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] data);
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      rtt_pkg::RegInitRto: begin
        p_init = data;
        if (!p_have) p_base = data;
      end
      rtt_pkg::RegFloor: p_floor = data;
      rtt_pkg::RegCeil:  p_ceil = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [19:0] init, input logic [19:0] flr,
                          input logic [19:0] ceil);
    write_reg(rtt_pkg::RegInitRto, init);
    write_reg(rtt_pkg::RegFloor, flr);
    write_reg(rtt_pkg::RegCeil, ceil);
  endtask

  task automatic run_phase(input int n);
    int          r;
    logic [1:0]  c;
    logic [31:0] a, span;
    logic [15:0] l;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 29) == 0) clk_ms = 48'({$urandom(), $urandom()});
      else clk_ms = clk_ms + $urandom_range(0, 600);
      a = $urandom();
      l = 16'($urandom());
      if (r < 40) begin
        c = rtt_pkg::CmdSend;
        if ($urandom_range(0, 9) != 0) l = 16'($urandom_range(0, 1200));
      end else if (r < 70) begin
        c = rtt_pkg::CmdTick;
      end else if (r < 97) begin
        c = rtt_pkg::CmdAck;
        span = (p_next > p_high) ? p_next - p_high - 32'd1 : 32'd0;
        if ($urandom_range(0, 7) == 0) a = $urandom_range(0, p_high);
        else a = p_high + $urandom_range(1, span + 1);
      end else begin
        c = CmdNone;
      end
      drive_cmd(c, clk_ms, a, l);
    end
  endtask

  // result stall patterns, plus a long hold-off on request
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(20, 80);
        end
        left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= $urandom_range(0, 1);
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    rto_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: status %0d", status_o);
      end else begin
        exp_r = expected_q.pop_front();
        if (status_o !== exp_r.status || seq_out_o !== exp_r.seq ||
            slot_out_o !== exp_r.slot || in_flight_o !== exp_r.in_flight ||
            base_rto_out_o !== exp_r.base_rto) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d seq %0d slot %0d inflt %0d rto %0d / got %0d %0d %0d %0d %0d",
                     exp_r.status, exp_r.seq, exp_r.slot, exp_r.in_flight, exp_r.base_rto,
                     status_o, seq_out_o, slot_out_o, in_flight_o, base_rto_out_o);
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("retransmit_timer_rto_tracker_tb: done, errors");
    $finish;
  end

  initial begin
    p_init = 20'd1000;
    p_floor = 20'd200;
    p_ceil = 20'd60000;
    foreach (p_valid[i]) p_valid[i] = 0;
    p_next = 32'd1;
    p_high = '0;
    p_count = 0;
    p_have = 0;
    p_srtt = '0;
    p_var = '0;
    p_base = 20'd1000;

    directed[0]  = '{rtt_pkg::CmdAck,  48'd0, 32'd0, 16'd0, 1,
                     {rtt_pkg::StStale, 32'd0, 6'd0, 7'd0, 20'd1000}};
    directed[1]  = '{rtt_pkg::CmdTick, 48'd0, 32'd0, 16'd0, 1,
                     {rtt_pkg::StNone, 32'd0, 6'd0, 7'd0, 20'd1000}};
    directed[2]  = '{rtt_pkg::CmdSend, 48'd0, 32'd0, 16'd1201, 1,
                     {rtt_pkg::StTooLong, 32'd0, 6'd0, 7'd0, 20'd1000}};
    directed[3]  = '{rtt_pkg::CmdSend, 48'd0, 32'd0, 16'hFFFF, 1,
                     {rtt_pkg::StTooLong, 32'd0, 6'd0, 7'd0, 20'd1000}};
    directed[4]  = '{CmdNone, rtt_pkg::M48, 32'hFFFF_FFFF, 16'hFFFF, 1,
                     {rtt_pkg::StNone, 32'd0, 6'd0, 7'd0, 20'd1000}};
    directed[5]  = '{rtt_pkg::CmdSend, 48'd100, 32'd0, 16'd0, 1,
                     {rtt_pkg::StSent, 32'd1, 6'd0, 7'd1, 20'd1000}};
    directed[6]  = '{rtt_pkg::CmdSend, 48'd100, 32'd0, 16'd1200, 1,
                     {rtt_pkg::StSent, 32'd2, 6'd1, 7'd2, 20'd1000}};
    directed[7]  = '{rtt_pkg::CmdTick, 48'd1099, 32'd0, 16'd0, 1,
                     {rtt_pkg::StNone, 32'd0, 6'd0, 7'd2, 20'd1000}};
    directed[8]  = '{rtt_pkg::CmdTick, 48'd1100, 32'd0, 16'd0, 1,
                     {rtt_pkg::StRetx, 32'd1, 6'd0, 7'd2, 20'd1000}};
    directed[9]  = '{rtt_pkg::CmdTick, 48'd1100, 32'd0, 16'd0, 1,
                     {rtt_pkg::StRetx, 32'd2, 6'd1, 7'd2, 20'd1000}};
    directed[10] = '{rtt_pkg::CmdSend, 48'd2000, 32'd0, 16'd5, 1,
                     {rtt_pkg::StSent, 32'd3, 6'd2, 7'd3, 20'd1000}};
    directed[11] = '{rtt_pkg::CmdAck,  48'd2100, 32'd2, 16'd0, 1,
                     {rtt_pkg::StNone, 32'd0, 6'd0, 7'd1, 20'd1000}};
    directed[12] = '{rtt_pkg::CmdAck,  48'd2300, 32'd3, 16'd0, 1,
                     {rtt_pkg::StNone, 32'd0, 6'd0, 7'd0, 20'd900}};
    directed[13] = '{rtt_pkg::CmdAck,  48'd2400, 32'd3, 16'd0, 1,
                     {rtt_pkg::StStale, 32'd0, 6'd0, 7'd0, 20'd900}};
    // time going backwards, saturated sample, saturated due time
    directed[14] = '{rtt_pkg::CmdSend, 48'd5000, 32'd0, 16'd1200, 0, '0};
    directed[15] = '{rtt_pkg::CmdAck,  48'd10, 32'd4, 16'd0, 0, '0};
    directed[16] = '{rtt_pkg::CmdSend, 48'd20000, 32'd0, 16'd1, 0, '0};
    directed[17] = '{rtt_pkg::CmdAck,  48'h100_0000_0000, 32'd5, 16'd0, 0, '0};
    directed[18] = '{rtt_pkg::CmdSend, rtt_pkg::M48, 32'd0, 16'd1, 0, '0};
    directed[19] = '{rtt_pkg::CmdTick, rtt_pkg::M48, 32'd0, 16'd0, 0, '0};
    directed[20] = '{rtt_pkg::CmdAck,  rtt_pkg::M48, 32'd6, 16'd0, 0, '0};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(rtt_pkg::RegInitRto, 20'd1000);
    foreach (directed[i])
      drive_cmd(directed[i].cmd, directed[i].now, directed[i].ack, directed[i].len,
                directed[i].typed, directed[i].res);
    clk_ms = 48'd3000;
    // fill the window and one more
    for (int k = 0; k < NSlots + 1; k++) drive_cmd(rtt_pkg::CmdSend, clk_ms, 32'd0, 16'd64);

    set_regs(20'd300, 20'd50, 20'd5000);
    hold_req = 1;
    run_phase(100);
    set_regs(20'd0, 20'd0, 20'd0);
    run_phase(60);
    set_regs(rtt_pkg::M20, rtt_pkg::M20, rtt_pkg::M20);
    run_phase(60);
    set_regs(20'($urandom()), 20'($urandom()), 20'($urandom()));
    run_phase(100);
    write_reg(RegUnused, 20'($urandom()));
    set_regs(20'd1000, 20'd200, 20'd60000);
    run_phase(150);
    drive_cmd(rtt_pkg::CmdAck, clk_ms, 32'hFFFF_FFFF, 16'hFFFF);

    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d commands: %0d sent, %0d retransmitted, %0d window full, %0d too long,",
             items, status_seen[rtt_pkg::StSent], status_seen[rtt_pkg::StRetx],
             status_seen[rtt_pkg::StFull], status_seen[rtt_pkg::StTooLong]);
    $display("  %0d stale acks, %0d applied or idle; %0d mismatches",
             status_seen[rtt_pkg::StStale], status_seen[rtt_pkg::StNone], mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("retransmit_timer_rto_tracker_tb: done, clean");
    end else begin
      $display("retransmit_timer_rto_tracker_tb: done, errors");
    end
    $finish;
  end
endmodule
